// ===== rtl/bqsu_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bqsu_pkg
// Shared types and codes for the bounded queue with search and update.
// ---------------------------------------------------------------------------
package bqsu_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 4;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] replacement;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry_value;
    logic [OCC_W-1:0]         occupancy;
  } out_t;

  // broadcast controls from the queue control to every cell
  typedef struct packed {
    logic                     shift;
    logic                     ins;
    logic                     upd;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] repl;
  } cell_ctrl_t;

endpackage : bqsu_pkg
`default_nettype wire

// ===== rtl/bounded_queue_with_search_update.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bounded_queue_with_search_update
// Bounded FIFO of signed 32-bit values with first-match search and update,
// built as a row of cells with the head always in cell 0.
// ---------------------------------------------------------------------------
//
//  channel  valid      stall      payload   beat
//  in       in_valid   in_stall   in_data   command: action, value, replacement
//  out      out_valid  out_stall  out_data  result: status, entry_value, occupancy
//
//  insert, remove, and search/update on an empty queue: result registered in the
//  cycle after the command beat. search/update: a token walks the cells one per
//  cycle from the head, and the result is registered once the token meets a match
//  or, with no match, once it reaches the last entry.
//  one command in flight; the next beat is taken once the result is out.
//  synchronous active-low reset empties the queue; entry values are not cleared.
//  in_stall is high while a search walks or an unread result waits under stall.
//
module bounded_queue_with_search_update
  import bqsu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  // control state
  logic          busy_r, busy_nxt;
  logic          upd_r, upd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic signed [DATA_W-1:0] repl_r, repl_nxt;
  out_t                     out_r, out_nxt;

  logic       accept, ins_go, rem_go, srch_cmd, start, load, done;
  logic       full, empty, hit, miss;
  cell_ctrl_t ctrl;

  logic                     occ      [DEPTH];
  logic signed [DATA_W-1:0] cell_data[DEPTH];
  logic                     tok_in   [DEPTH];
  logic                     tok_out  [DEPTH];
  logic [DEPTH-1:0]         hit_vec, miss_vec, tok_vec;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // one command at a time; output register frees the slot on the taking edge
  assign in_stall = busy_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign srch_cmd = (in_data.action == ACT_SEARCH) || (in_data.action == ACT_UPDATE);
  assign ins_go   = accept && (in_data.action == ACT_INSERT) && !full;
  assign rem_go   = accept && (in_data.action == ACT_REMOVE) && !empty;
  assign start    = accept && srch_cmd && !empty;
  assign load     = accept && !start;

  assign hit  = |hit_vec;
  assign miss = |miss_vec;
  assign done = busy_r && (hit || miss);

  // broadcast controls; the key comes straight from the beat for insert
  always_comb begin
    ctrl.shift = rem_go;
    ctrl.ins   = ins_go;
    ctrl.upd   = busy_r && upd_r;
    ctrl.key   = busy_r ? key_r : in_data.value;
    ctrl.repl  = repl_r;
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     prev_occ, next_occ;
    logic signed [DATA_W-1:0] next_data;

    assign occ[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_occ  = 1'b1;
      assign tok_in[i] = start;
    end else begin : g_body
      assign prev_occ  = occ[i-1];
      assign tok_in[i] = tok_out[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_occ  = 1'b0;
      assign next_data = '0;
    end else begin : g_mid
      assign next_occ  = occ[i+1];
      assign next_data = cell_data[i+1];
    end

    bqsu_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .prev_occ_i  (prev_occ),
      .next_occ_i  (next_occ),
      .next_data_i (next_data),
      .tok_i       (tok_in[i]),
      .data_o      (cell_data[i]),
      .tok_o       (tok_out[i]),
      .hit_o       (hit_vec[i]),
      .miss_o      (miss_vec[i]),
      .tok_held_o  (tok_vec[i])
    );
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (ins_go) begin
      count_nxt = count_r + CW'(1);
    end else if (rem_go) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // command capture and search walk
  always_comb begin
    busy_nxt = busy_r;
    upd_nxt  = upd_r;
    key_nxt  = key_r;
    repl_nxt = repl_r;
    if (start) begin
      busy_nxt = 1'b1;
      upd_nxt  = (in_data.action == ACT_UPDATE);
      key_nxt  = in_data.value;
      repl_nxt = in_data.replacement;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_nxt.occupancy     = OCC_W'(count_nxt);
      out_nxt.entry_value   = '0;
      out_nxt.status        = ST_OK;
      case (in_data.action)
        ACT_INSERT: begin
          if (full) begin
            out_nxt.status = ST_OVERFLOW;
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            out_nxt.status = ST_UNDERFLOW;
          end else begin
            out_nxt.entry_value = cell_data[0];
          end
        end
        default: begin
          // search or update on an empty queue
          out_nxt.status = ST_NOT_FOUND;
        end
      endcase
    end else if (done) begin
      out_valid_nxt       = 1'b1;
      out_nxt.occupancy   = OCC_W'(count_r);
      // a match equals the key, so the key is the matched value
      out_nxt.status      = hit ? ST_OK : ST_NOT_FOUND;
      out_nxt.entry_value = hit ? key_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upd_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      upd_r       <= upd_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    repl_r <= repl_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // at most one cell carries the search token
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one search token in the cell row");

  // the token lives only while a search walks
  a_tok_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_vec != '0) |-> busy_r)
    else $error("search token outside a search");

  // a walking search never shares the output with another result
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !out_valid_r)
    else $error("result pending while a search walks");

  // occupancy stays within depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy beyond depth");
`endif

endmodule : bounded_queue_with_search_update
`default_nettype wire

// ===== rtl/bqsu_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bqsu_cell
// One queue entry: holds a value, shifts toward the head on remove, takes
// the insert when it is the first free slot, and passes the search token on.
// ---------------------------------------------------------------------------
module bqsu_cell
  import bqsu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic                     occ_i,
  input  wire logic                     prev_occ_i,
  input  wire logic                     next_occ_i,
  input  wire logic signed [DATA_W-1:0] next_data_i,
  input  wire logic                     tok_i,
  output logic signed [DATA_W-1:0]      data_o,
  output logic                          tok_o,
  output logic                          hit_o,
  output logic                          miss_o,
  output logic                          tok_held_o
);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     tok_r, tok_nxt;
  logic                     match;

  assign match = occ_i && (data_r == ctrl_i.key);

  assign hit_o      = tok_r && match;
  assign miss_o     = tok_r && !match && !next_occ_i;
  assign tok_o      = tok_r && !match && next_occ_i;
  assign tok_held_o = tok_r;
  assign data_o     = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl_i.shift) begin
      data_nxt = next_data_i;
    end else if (ctrl_i.ins && !occ_i && prev_occ_i) begin
      data_nxt = ctrl_i.key;
    end else if (ctrl_i.upd && hit_o) begin
      data_nxt = ctrl_i.repl;
    end
  end

  assign tok_nxt = tok_i;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

endmodule : bqsu_cell
`default_nettype wire
